>>> hdl/mlsd_pkg.sv
// ----------------------------------------------------------------------------
// mlsd_pkg
// Shared types, constants and LFSR helpers for the duobinary line sync
// slicer and descrambler.
// ----------------------------------------------------------------------------
package mlsd_pkg;

    // Scrambler width and first-line seed
    localparam int LFSR_W = 15;
    localparam logic [LFSR_W-1:0] SEED_FIRST = 15'h7FFF;

    // Line sync words, oldest symbol in the LSB
    localparam logic [5:0] WORD_A = 6'h34;
    localparam logic [5:0] WORD_B = 6'h0B;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_SLICE_LOW  = 1'b0;
    localparam logic REG_SLICE_HIGH = 1'b1;
    localparam logic [7:0] SLICE_LOW_RST  = 8'd85;
    localparam logic [7:0] SLICE_HIGH_RST = 8'd170;

    typedef logic [LFSR_W-1:0] lfsr_t;
    typedef logic [LFSR_W-1:0][LFSR_W-1:0] jump_mat_t;

    // Front end line state
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SEARCH,
        MODE_CAPTURE,
        MODE_DONE
    } mode_t;

    // Token kinds passed from front to back
    typedef enum logic [1:0] {
        TOK_LINE,
        TOK_SYNC,
        TOK_DATA
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic        frame_start;
        logic        sync_word;
        logic        slice_bit;
        logic [6:0]  bit_index;
        logic        last;
    } token_t;

    typedef struct packed {
        logic        out_kind;
        logic        sync_word;
        logic        data_bit;
        logic [6:0]  bit_index;
        logic        last_in_line;
    } result_t;

    // One PRBS step: feedback x[0]^x[14] shifts in at the top
    function automatic lfsr_t lfsr_step(lfsr_t x);
        lfsr_step = {x[0] ^ x[LFSR_W-1], x[LFSR_W-1:1]};
    endfunction

    // Column j holds unit vector j advanced by the given number of steps
    function automatic jump_mat_t jump_matrix(int steps);
        jump_mat_t m;
        lfsr_t     v;
        int        j;
        int        k;
        for (j = 0; j < LFSR_W; j++)
        begin
            v = lfsr_t'(1) << j;
            for (k = 0; k < steps; k++)
            begin
                v = lfsr_step(v);
            end
            m[j] = v;
        end
        jump_matrix = m;
    endfunction

    // GF(2) matrix times state
    function automatic lfsr_t jump_apply(jump_mat_t m, lfsr_t s);
        lfsr_t acc;
        int    j;
        acc = '0;
        for (j = 0; j < LFSR_W; j++)
        begin
            if (s[j])
            begin
                acc = acc ^ m[j];
            end
        end
        jump_apply = acc;
    endfunction

endpackage

>>> hdl/mlsd_fifo.sv
// ----------------------------------------------------------------------------
// mlsd_fifo
// Small show-ahead register FIFO; DEPTH is a power of two.
// ----------------------------------------------------------------------------
module mlsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hdl/mlsd_front.sv
// ----------------------------------------------------------------------------
// mlsd_front
// Slices each sample, tracks line state, searches for the sync word and
// classifies each sample into line, sync or data tokens.
// ----------------------------------------------------------------------------
module mlsd_front #(
    parameter int SPS  = 2,
    parameter int BITS = 99
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        sample,
    input  logic              line_start,
    input  logic              frame_start,
    input  logic [7:0]        slice_low,
    input  logic [7:0]        slice_high,
    output logic              tok_valid,
    output mlsd_pkg::token_t  tok
);

    localparam int HIST_LEN = 5 * SPS + 1;
    localparam int FILL_W   = $clog2(HIST_LEN + 1);
    localparam int GAP_RAW  = SPS + SPS / 2 - 1;
    localparam int GAP      = (GAP_RAW < 1) ? 1 : GAP_RAW;
    localparam int PH_MAX   = (GAP > SPS) ? GAP : SPS;
    localparam int PH_W     = $clog2(PH_MAX + 1);

    mlsd_pkg::mode_t     mode_reg;
    mlsd_pkg::mode_t     mode_next;
    mlsd_pkg::mode_t     mode_cur;
    logic [HIST_LEN-1:0] hist_reg;
    logic [HIST_LEN-1:0] hist_next;
    logic [HIST_LEN-1:0] hist_cur;
    logic [HIST_LEN-1:0] hist_shift;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic [FILL_W-1:0]   fill_cur;
    logic [FILL_W-1:0]   fill_inc;
    logic [PH_W-1:0]     phase_reg;
    logic [PH_W-1:0]     phase_next;
    logic [PH_W-1:0]     phase_cur;
    logic [PH_W-1:0]     phase_dec;
    logic [6:0]          bits_reg;
    logic [6:0]          bits_next;
    logic [6:0]          bits_cur;
    logic [5:0]          word;
    logic                slice_bit;
    logic                match;
    logic                data_now;
    logic                last_bit;

    // Three-level slicer
    assign slice_bit = (sample <= slice_low) || (sample > slice_high);

    // Line start restarts the search on this very sample
    assign mode_cur  = line_start ? mlsd_pkg::MODE_SEARCH : mode_reg;
    assign hist_cur  = line_start ? '0 : hist_reg;
    assign fill_cur  = line_start ? '0 : fill_reg;
    assign phase_cur = line_start ? '0 : phase_reg;
    assign bits_cur  = line_start ? '0 : bits_reg;

    // Sync search on each sample over every SPS-th slice of the history
    always_comb
    begin
        hist_shift = {hist_cur[HIST_LEN-2:0], slice_bit};
        fill_inc   = (fill_cur < FILL_W'(HIST_LEN)) ? fill_cur + FILL_W'(1) : fill_cur;
        for (int i = 0; i < 6; i++)
        begin
            word[i] = hist_shift[(5 - i) * SPS];
        end
        match = (fill_inc == FILL_W'(HIST_LEN))
             && ((word == mlsd_pkg::WORD_A) || (word == mlsd_pkg::WORD_B));
    end

    // Capture timing
    assign phase_dec = (phase_cur != '0) ? phase_cur - PH_W'(1) : '0;
    assign data_now  = (mode_cur == mlsd_pkg::MODE_CAPTURE) && (phase_dec == '0);
    assign last_bit  = (bits_cur == 7'(BITS - 1));

    // Next state
    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            case (mode_cur)
                mlsd_pkg::MODE_SEARCH:
                begin
                    mode_next = match ? mlsd_pkg::MODE_CAPTURE : mlsd_pkg::MODE_SEARCH;
                end
                mlsd_pkg::MODE_CAPTURE:
                begin
                    mode_next = (data_now && last_bit) ? mlsd_pkg::MODE_DONE
                                                       : mlsd_pkg::MODE_CAPTURE;
                end
                mlsd_pkg::MODE_DONE:
                begin
                    mode_next = mlsd_pkg::MODE_DONE;
                end
                default:
                begin
                    mode_next = mlsd_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    // Token output
    always_comb
    begin
        tok             = '0;
        tok.frame_start = frame_start;
        tok.slice_bit   = slice_bit;
        tok_valid       = 1'b0;
        if (line_start)
        begin
            tok.kind  = mlsd_pkg::TOK_LINE;
            tok_valid = accept;
        end
        else
        begin
            case (mode_cur)
                mlsd_pkg::MODE_SEARCH:
                begin
                    tok.kind      = mlsd_pkg::TOK_SYNC;
                    tok.sync_word = (word == mlsd_pkg::WORD_B);
                    tok_valid     = accept && match;
                end
                mlsd_pkg::MODE_CAPTURE:
                begin
                    tok.kind      = mlsd_pkg::TOK_DATA;
                    tok.bit_index = bits_cur;
                    tok.last      = last_bit;
                    tok_valid     = accept && data_now;
                end
                default:
                begin
                    tok_valid = 1'b0;
                end
            endcase
        end
    end

    // Search history, fill, phase and bit counters
    always_comb
    begin
        hist_next  = hist_cur;
        fill_next  = fill_cur;
        phase_next = phase_cur;
        bits_next  = bits_cur;
        if (mode_cur == mlsd_pkg::MODE_SEARCH)
        begin
            hist_next = hist_shift;
            fill_next = fill_inc;
            if (match)
            begin
                phase_next = PH_W'(GAP);
            end
        end
        else if (mode_cur == mlsd_pkg::MODE_CAPTURE)
        begin
            phase_next = phase_dec;
            if (data_now)
            begin
                bits_next = bits_cur + 7'd1;
                if (!last_bit)
                begin
                    phase_next = PH_W'(SPS);
                end
            end
        end
    end

    // Line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= mlsd_pkg::MODE_IDLE;
            hist_reg  <= '0;
            fill_reg  <= '0;
            phase_reg <= '0;
            bits_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            hist_reg  <= hist_next;
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
        end
    end

endmodule

>>> hdl/mlsd_back.sv
// ----------------------------------------------------------------------------
// mlsd_back
// Carries out tokens: reseeds the scrambler at each line and descrambles
// captured bits into result transactions.
// ----------------------------------------------------------------------------
module mlsd_back #(
    parameter int JUMP = 648
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  mlsd_pkg::token_t  tok,
    input  logic              out_full,
    output logic              tok_take,
    output logic              out_push,
    output mlsd_pkg::result_t result
);

    localparam mlsd_pkg::jump_mat_t JUMP_MAT = mlsd_pkg::jump_matrix(JUMP);

    mlsd_pkg::lfsr_t scram_reg;
    mlsd_pkg::lfsr_t scram_next;
    mlsd_pkg::lfsr_t seed_reg;
    mlsd_pkg::lfsr_t seed_next;
    logic            is_line;

    // Line tokens need no room on the result side
    assign is_line  = (tok.kind == mlsd_pkg::TOK_LINE);
    assign tok_take = tok_valid && (is_line || !out_full);
    assign out_push = tok_take && !is_line;

    // Token execution
    always_comb
    begin
        seed_next  = seed_reg;
        scram_next = scram_reg;
        result     = '0;
        case (tok.kind)
            mlsd_pkg::TOK_LINE:
            begin
                seed_next  = tok.frame_start ? mlsd_pkg::SEED_FIRST
                                             : mlsd_pkg::jump_apply(JUMP_MAT, seed_reg);
                scram_next = seed_next;
            end
            mlsd_pkg::TOK_SYNC:
            begin
                result.out_kind  = 1'b0;
                result.sync_word = tok.sync_word;
            end
            mlsd_pkg::TOK_DATA:
            begin
                scram_next          = mlsd_pkg::lfsr_step(scram_reg);
                result.out_kind     = 1'b1;
                result.data_bit     = tok.slice_bit ^ scram_next[mlsd_pkg::LFSR_W-1];
                result.bit_index    = tok.bit_index;
                result.last_in_line = tok.last;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // Seed and scrambler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= mlsd_pkg::SEED_FIRST;
            scram_reg <= mlsd_pkg::SEED_FIRST;
        end
        else if (tok_take)
        begin
            seed_reg  <= seed_next;
            scram_reg <= scram_next;
        end
    end

endmodule

>>> hdl/mac_line_sync_slicer_descrambler_core.sv
// ----------------------------------------------------------------------------
// mac_line_sync_slicer_descrambler_core
// Duobinary line sync detector and line descrambler with APB thresholds.
// ----------------------------------------------------------------------------
// Takes one video sample per clock and can keep that up indefinitely while
// pop keeps pace. Each sample is sliced and classified by the front end in the
// cycle it is pushed; line, sync and data tokens then wait in a four-entry
// queue for the back end, which carries out one token per cycle while the
// output queue has room (one scrambler step or one 648-step seed jump, done as
// a single GF(2) matrix product) and writes results into a two-entry output
// queue; results reach the result ports through both registered queues. full
// rises only when results are not popped. Thresholds are written at byte
// addresses 0 (slice_low) and 4 (slice_high) only while the block is idle;
// this is a rule for the user that the block itself does not enforce.
module mac_line_sync_slicer_descrambler_core #(
    parameter int SAMPLES_PER_SYMBOL = 2,
    parameter int BITS_PER_LINE      = 99,
    parameter int SEED_JUMP_STEPS    = 648
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Sample side
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      sample,
    input  logic                            line_start,
    input  logic                            frame_start,
    // Result side
    input  logic                            pop,
    output logic                            empty,
    output logic                            out_kind,
    output logic                            sync_word,
    output logic                            data_bit,
    output logic [6:0]                      bit_index,
    output logic                            last_in_line,
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mlsd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mlsd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mlsd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int TOK_W = $bits(mlsd_pkg::token_t);
    localparam int RES_W = $bits(mlsd_pkg::result_t);

    logic [7:0]        slice_low_reg;
    logic [7:0]        slice_high_reg;
    logic              cfg_wr;
    logic              accept;
    logic              ftok_valid;
    mlsd_pkg::token_t  ftok;
    mlsd_pkg::token_t  qtok;
    logic [TOK_W-1:0]  qtok_bits;
    logic              q_empty;
    logic              tok_take;
    logic              out_push;
    logic              out_full;
    mlsd_pkg::result_t bres;
    mlsd_pkg::result_t ores;
    logic [RES_W-1:0]  ores_bits;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_low_reg  <= mlsd_pkg::SLICE_LOW_RST;
            slice_high_reg <= mlsd_pkg::SLICE_HIGH_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                mlsd_pkg::REG_SLICE_LOW:  slice_low_reg  <= pwdata[7:0];
                mlsd_pkg::REG_SLICE_HIGH: slice_high_reg <= pwdata[7:0];
                default:                  slice_low_reg  <= slice_low_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            mlsd_pkg::REG_SLICE_LOW:  prdata = {24'd0, slice_low_reg};
            mlsd_pkg::REG_SLICE_HIGH: prdata = {24'd0, slice_high_reg};
            default:                  prdata = '0;
        endcase
    end

    // Front end
    assign accept = push && !full;

    mlsd_front #(
        .SPS  (SAMPLES_PER_SYMBOL),
        .BITS (BITS_PER_LINE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .sample      (sample),
        .line_start  (line_start),
        .frame_start (frame_start),
        .slice_low   (slice_low_reg),
        .slice_high  (slice_high_reg),
        .tok_valid   (ftok_valid),
        .tok         (ftok)
    );

    // Token queue between front and back
    mlsd_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (4)
    ) u_tok_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ftok_valid),
        .wr_data (ftok),
        .rd_en   (tok_take),
        .rd_data (qtok_bits),
        .full    (full),
        .empty   (q_empty)
    );

    assign qtok = mlsd_pkg::token_t'(qtok_bits);

    // Back end
    mlsd_back #(
        .JUMP (SEED_JUMP_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (!q_empty),
        .tok       (qtok),
        .out_full  (out_full),
        .tok_take  (tok_take),
        .out_push  (out_push),
        .result    (bres)
    );

    // Result queue
    mlsd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (bres),
        .rd_en   (pop),
        .rd_data (ores_bits),
        .full    (out_full),
        .empty   (empty)
    );

    assign ores         = mlsd_pkg::result_t'(ores_bits);
    assign out_kind     = ores.out_kind;
    assign sync_word    = ores.sync_word;
    assign data_bit     = ores.data_bit;
    assign bit_index    = ores.bit_index;
    assign last_in_line = ores.last_in_line;

`ifndef SYNTH
    // Data results never index past the line
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind) |-> (bit_index <= 7'(BITS_PER_LINE - 1)))
        else $error("bit_index beyond line length");

    // Line end flag only on the final data bit
    a_last_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_in_line) |-> (out_kind && (bit_index == 7'(BITS_PER_LINE - 1))))
        else $error("last_in_line on wrong result");

    // Back end only writes results when there is room
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result queue overflow");

    // Sync results carry clean data fields
    a_sync_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_kind) |-> (!data_bit && !last_in_line && (bit_index == 7'd0)))
        else $error("sync result with data fields set");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the duobinary line sync slicer and descrambler.
// ----------------------------------------------------------------------------
// A short table of hand-picked samples runs first: samples before any line
// start, a line carrying the 0x0B sync word with its first data bit, and a
// line with a seed jump carrying 0x34. Random lines follow under several
// threshold settings, the crossed and extreme ones among them. Most random
// lines are well formed (preamble, sync word, a full line of data, a tail).
// The rest are noise, broken sync words or lines cut short. Every accepted
// sample runs through an in-bench line model. Its results queue up and are
// compared field by field as the block delivers them.
module tb;

    localparam int SPS       = 2;
    localparam int BITS      = 99;
    localparam int JUMP      = 648;
    localparam int HIST_W    = 5 * SPS + 1;
    localparam int FIRST_GAP = (SPS + SPS / 2 - 1) < 1 ? 1 : (SPS + SPS / 2 - 1);
    localparam int SETTLE    = 24;

    localparam logic KIND_SYNC = 1'b0;
    localparam logic KIND_DATA = 1'b1;
    localparam logic SW_A      = 1'b0;
    localparam logic SW_B      = 1'b1;

    typedef struct {
        logic [7:0]        sample;
        logic              ls;
        logic              fs;
        bit                fixed;
        bit                want_n;
        mlsd_pkg::result_t want;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            push;
    logic                            full;
    logic [7:0]                      sample;
    logic                            line_start;
    logic                            frame_start;
    logic                            pop = 1'b0;
    logic                            empty;
    logic                            out_kind;
    logic                            sync_word;
    logic                            data_bit;
    logic [6:0]                      bit_index;
    logic                            last_in_line;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mlsd_pkg::APB_ADDR_W-1:0] paddr;
    logic [mlsd_pkg::APB_DATA_W-1:0] pwdata;
    logic [mlsd_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Line model state
    logic [7:0]        thr_low;
    logic [7:0]        thr_high;
    mlsd_pkg::lfsr_t   pr_lfsr;
    mlsd_pkg::lfsr_t   pr_seed;
    logic [HIST_W-1:0] pr_hist;
    int                pr_fill;
    mlsd_pkg::mode_t   pr_mode;
    int                pr_wait;
    logic [6:0]        pr_taken;

    mlsd_pkg::result_t exp_results[$];
    stim_row_t         dir_rows[$];
    stim_row_t         cur_row;
    int                errors;
    int                items_sent;
    int                burst_left;
    int                gap_left;
    int                rx_left = 0;
    int                rx_mode = 0;

    mac_line_sync_slicer_descrambler_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .sample       (sample),
        .line_start   (line_start),
        .frame_start  (frame_start),
        .pop          (pop),
        .empty        (empty),
        .out_kind     (out_kind),
        .sync_word    (sync_word),
        .data_bit     (data_bit),
        .bit_index    (bit_index),
        .last_in_line (last_in_line),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit slice_level(logic [7:0] s);
        slice_level = (s <= thr_low) || (s > thr_high);
    endfunction

    // Pick a level that slices to the wanted bit under the current thresholds; any level where none slices to zero
    function automatic logic [7:0] level_for(bit want);
        if (want)
        begin
            if (thr_high < 8'd255 && $urandom_range(0, 1))
                level_for = 8'($urandom_range(int'(thr_high) + 1, 255));
            else
                level_for = 8'($urandom_range(0, int'(thr_low)));
        end
        else if (thr_low < thr_high)
        begin
            level_for = 8'($urandom_range(int'(thr_low) + 1, int'(thr_high)));
        end
        else
        begin
            level_for = 8'($urandom_range(0, 255));
        end
    endfunction

    function automatic stim_row_t mk_row(logic [7:0] s, logic ls, logic fs, bit fixed,
                                         bit n, logic kind, logic sw, logic db,
                                         logic [6:0] idx, logic last);
        stim_row_t r;
        r.sample            = s;
        r.ls                = ls;
        r.fs                = fs;
        r.fixed             = fixed;
        r.want_n            = n;
        r.want.out_kind     = kind;
        r.want.sync_word    = sw;
        r.want.data_bit     = db;
        r.want.bit_index    = idx;
        r.want.last_in_line = last;
        mk_row = r;
    endfunction

    // Line model: one accepted sample, at most one result
    task automatic predict_line_sample(input logic [7:0] s, input logic ls, input logic fs,
                                       output bit got, output mlsd_pkg::result_t r);
        bit         b;
        bit         fb;
        logic [5:0] w;
        int         i;
        int         k;
        got = 1'b0;
        r   = '0;
        if (ls)
        begin
            if (fs)
            begin
                pr_seed = mlsd_pkg::SEED_FIRST;
            end
            else
            begin
                for (k = 0; k < JUMP; k++)
                begin
                    fb      = pr_seed[0] ^ pr_seed[mlsd_pkg::LFSR_W-1];
                    pr_seed = {fb, pr_seed[mlsd_pkg::LFSR_W-1:1]};
                end
            end
            pr_lfsr  = pr_seed;
            pr_hist  = '0;
            pr_fill  = 0;
            pr_mode  = mlsd_pkg::MODE_SEARCH;
            pr_wait  = 0;
            pr_taken = '0;
        end
        b = slice_level(s);
        if (pr_mode == mlsd_pkg::MODE_SEARCH)
        begin
            pr_hist = {pr_hist[HIST_W-2:0], b};
            if (pr_fill < HIST_W)
                pr_fill++;
            if (pr_fill >= HIST_W)
            begin
                for (i = 0; i < 6; i++)
                    w[i] = pr_hist[(5 - i) * SPS];
                if (w == mlsd_pkg::WORD_A || w == mlsd_pkg::WORD_B)
                begin
                    pr_mode     = mlsd_pkg::MODE_CAPTURE;
                    pr_wait     = FIRST_GAP;
                    got         = 1'b1;
                    r.out_kind  = KIND_SYNC;
                    r.sync_word = (w == mlsd_pkg::WORD_B) ? SW_B : SW_A;
                end
            end
        end
        else if (pr_mode == mlsd_pkg::MODE_CAPTURE)
        begin
            if (pr_wait > 0)
                pr_wait--;
            if (pr_wait == 0)
            begin
                fb             = pr_lfsr[0] ^ pr_lfsr[mlsd_pkg::LFSR_W-1];
                pr_lfsr        = {fb, pr_lfsr[mlsd_pkg::LFSR_W-1:1]};
                got            = 1'b1;
                r.out_kind     = KIND_DATA;
                r.data_bit     = b ^ fb;
                r.bit_index    = pr_taken;
                pr_taken       = pr_taken + 7'd1;
                r.last_in_line = (pr_taken >= BITS);
                if (r.last_in_line)
                    pr_mode = mlsd_pkg::MODE_DONE;
                else
                    pr_wait = SPS;
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            errors++;
        end
    endtask

    // Monitor: predict on accepted samples, compare on accepted results
    always @(posedge clk)
    begin : monitor
        bit                got;
        mlsd_pkg::result_t r;
        mlsd_pkg::result_t want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                predict_line_sample(sample, line_start, frame_start, got, r);
                if (cur_row.fixed)
                begin
                    got = cur_row.want_n;
                    r   = cur_row.want;
                end
                if (got)
                    exp_results.push_back(r);
            end
            if (pop && !empty)
            begin
                if (exp_results.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    errors++;
                end
                else
                begin
                    want = exp_results.pop_front();
                    check_field("out_kind", 32'(want.out_kind), 32'(out_kind));
                    check_field("sync_word", 32'(want.sync_word), 32'(sync_word));
                    check_field("data_bit", 32'(want.data_bit), 32'(data_bit));
                    check_field("bit_index", 32'(want.bit_index), 32'(bit_index));
                    check_field("last_in_line", 32'(want.last_in_line),
                                32'(last_in_line));
                end
            end
        end
    end

    // Receiver: runs of steady pop, stalls and random pop
    always @(negedge clk)
    begin : rx_pattern
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(1, (rx_mode == 2) ? 20 : 200);
        end
        rx_left--;
        case (rx_mode)
            2:       pop <= 1'b0;
            3:       pop <= ($urandom_range(0, 1) == 1);
            default: pop <= 1'b1;
        endcase
    end

    // Sender: one sample transaction, bursts with gaps in between
    task automatic send_row(input stim_row_t row);
        while (gap_left > 0)
        begin
            push = 1'b0;
            @(negedge clk);
            gap_left--;
        end
        push        = 1'b1;
        sample      = row.sample;
        line_start  = row.ls;
        frame_start = row.fs;
        cur_row     = row;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                burst_left = $urandom_range(150, 400);
                gap_left   = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 40);
                gap_left   = $urandom_range(1, 7);
            end
        end
    endtask

    task automatic send_sample(input logic [7:0] s, input logic ls, input logic fs);
        send_row(mk_row(s, ls, fs, 1'b0, 1'b0, KIND_SYNC, SW_A, 1'b0, 7'd0, 1'b0));
    endtask

    // Hold the sender until every expected result has come and the pipe is empty
    task automatic wait_drained();
        push = 1'b0;
        while (exp_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Threshold write with read back
    task automatic set_threshold(input logic idx, input logic [7:0] val);
        logic [mlsd_pkg::APB_DATA_W-1:0] rd;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = mlsd_pkg::APB_DATA_W'(val);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        if (idx == mlsd_pkg::REG_SLICE_LOW)
            thr_low = val;
        else
            thr_high = val;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        check_field("prdata", 32'(val), 32'(rd[7:0]));
    endtask

    // One random line: mostly preamble, sync word and a full line of data
    task automatic send_line();
        int         kind;
        int         n;
        int         i;
        int         j;
        logic [5:0] w;
        send_sample(8'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 3) == 0);
        kind = $urandom_range(0, 99);
        if (kind < 80)
        begin
            n = $urandom_range(0, 12);
            repeat (n) send_sample(8'($urandom_range(0, 255)), 1'b0,
                                   $urandom_range(0, 15) == 0);
            w = $urandom_range(0, 1) ? mlsd_pkg::WORD_B : mlsd_pkg::WORD_A;
            // broken sync word
            if (kind >= 68)
            begin
                j    = $urandom_range(0, 5);
                w[j] = ~w[j];
            end
            for (i = 0; i < 6; i++)
                repeat (SPS) send_sample(level_for(w[i]), 1'b0, $urandom_range(0, 15) == 0);
            // some lines are cut short by the next line start
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(10, 190);
            else
                n = 2 * BITS + $urandom_range(0, 12);
        end
        else
        begin
            n = $urandom_range(10, 60);
        end
        repeat (n) send_sample(level_for($urandom_range(0, 1) == 1), 1'b0,
                               $urandom_range(0, 15) == 0);
    endtask

    task automatic run_phase(input logic [7:0] lo, input logic [7:0] hi, input int target);
        int start;
        wait_drained();
        set_threshold(mlsd_pkg::REG_SLICE_LOW, lo);
        set_threshold(mlsd_pkg::REG_SLICE_HIGH, hi);
        start = items_sent;
        send_line();
        // sender holds off after the first line of each phase until all results are in
        wait_drained();
        while (items_sent - start < target)
            send_line();
    endtask

    // Main sequence
    initial
    begin
        int lo;
        rst_n       = 1'b0;
        push        = 1'b0;
        sample      = '0;
        line_start  = 1'b0;
        frame_start = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cur_row     = mk_row(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, KIND_SYNC, SW_A, 1'b0, 7'd0, 1'b0);
        errors      = 0;
        items_sent  = 0;
        burst_left  = 0;
        gap_left    = 0;
        thr_low     = mlsd_pkg::SLICE_LOW_RST;
        thr_high    = mlsd_pkg::SLICE_HIGH_RST;
        pr_lfsr     = mlsd_pkg::SEED_FIRST;
        pr_seed     = mlsd_pkg::SEED_FIRST;
        pr_hist     = '0;
        pr_fill     = 0;
        pr_mode     = mlsd_pkg::MODE_IDLE;
        pr_wait     = 0;
        pr_taken    = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table, reset thresholds 85 / 170
        // sample before any line start is ignored
        dir_rows.push_back(mk_row(8'd255, 0, 0, 1, 0, KIND_SYNC, SW_A, 0, 0, 0));
        // frame's first line, word 0x0B on the even samples
        dir_rows.push_back(mk_row(8'd0,   1, 1, 1, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd85,  0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd255, 0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd86,  0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd128, 0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd170, 0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd171, 0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd171, 0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd86,  0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd255, 0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        // first sample where the window is full: match
        dir_rows.push_back(mk_row(8'd170, 0, 0, 1, 1, KIND_SYNC, SW_B, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd0,   0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        // first data bit, first PRBS bit of seed 0x7FFF is zero
        dir_rows.push_back(mk_row(8'd255, 0, 0, 1, 1, KIND_DATA, SW_A, 1, 0, 0));
        // new line abandons the capture, seed jumps
        dir_rows.push_back(mk_row(8'd86,  1, 0, 1, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd255, 0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd128, 0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd0,   0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd0,   0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd128, 0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd170, 0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd171, 0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd85,  0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd86,  0, 0, 0, 0, KIND_SYNC, SW_A, 0, 0, 0));
        dir_rows.push_back(mk_row(8'd171, 0, 0, 1, 1, KIND_SYNC, SW_A, 0, 0, 0));
        foreach (dir_rows[i])
            send_row(dir_rows[i]);

        // Random lines under several threshold settings
        run_phase(8'd0, 8'd255, 180);
        run_phase(8'd255, 8'd0, 100);
        run_phase(8'd85, 8'd170, 220);
        run_phase(8'd100, 8'd101, 180);
        run_phase(8'd40, 8'd220, 180);
        lo = $urandom_range(0, 200);
        run_phase(8'(lo), 8'($urandom_range(lo + 1, 255)), 220);
        run_phase(8'd0, 8'd0, 60);

        wait_drained();
        if (errors == 0 && exp_results.size() == 0)
            $display("PASS mac_line_sync_slicer_descrambler_core");
        else
            $display("FAIL mac_line_sync_slicer_descrambler_core");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("FAIL mac_line_sync_slicer_descrambler_core");
        $finish;
    end

endmodule
